@@ src/drbrt_pkg.sv @@
// package for the dram bank row timing block
// types, register codes and event kinds shared by all modules; no dependencies

package drbrt_pkg;

    localparam int NUM_BANKS = 8;
    localparam int IDX_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int ADDR_W    = 48;
    localparam int ROW_W     = 32;
    localparam int ID_W      = 16;
    localparam int EBANK_W   = 3;
    localparam int LAT_W     = 8;
    localparam int SHIFT_W   = 5;
    localparam int DELAY_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [IDX_W-1:0] BANK_MASK = IDX_W'(NUM_BANKS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW       = 3'd5;

    // word kinds
    localparam logic [1:0] KIND_ISSUE     = 2'd0;
    localparam logic [1:0] KIND_ACCESS    = 2'd1;
    localparam logic [1:0] KIND_PRECHARGE = 2'd2;
    localparam logic [1:0] KIND_NONE      = 2'd0;

    // row outcomes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_EMPTY = 2'd1;
    localparam logic [1:0] OUT_WRONG = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  address;
        logic [ID_W-1:0]    req_id;
        logic [EBANK_W-1:0] event_bank;
    } item_t;

    typedef struct packed {
        logic               accepted;
        logic [1:0]         row_outcome;
        logic [EBANK_W-1:0] out_bank;
        logic               schedule_valid;
        logic [1:0]         schedule_kind;
        logic [DELAY_W-1:0] schedule_delay;
        logic               respond;
        logic [ID_W-1:0]    resp_req_id;
    } result_t;

    typedef struct packed {
        logic [LAT_W-1:0]   cas_latency;
        logic [LAT_W-1:0]   activate_latency;
        logic [LAT_W-1:0]   precharge_latency;
        logic               closed_policy;
        logic [SHIFT_W-1:0] line_shift;
        logic [SHIFT_W-1:0] row_shift;
    } cfg_t;

    typedef struct packed {
        logic             busy;
        logic             open;
        logic [ROW_W-1:0] row;
    } lkp_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] bank;
        logic             set_busy;
        logic             clr_busy;
        logic             set_open;
        logic             clr_open;
        logic [ROW_W-1:0] row;
    } upd_t;

endpackage

@@ src/drbrt_cfg_regs.sv @@
// configuration register file for the dram bank row timing block
// depends on drbrt_pkg

module drbrt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [drbrt_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [drbrt_pkg::CFG_DAT_W-1:0] wr_data,
    output drbrt_pkg::cfg_t                cfg
);

    drbrt_pkg::cfg_t cfg_reg;
    drbrt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                drbrt_pkg::REG_CAS:       cfg_next.cas_latency = wr_data;
                drbrt_pkg::REG_ACTIVATE:  cfg_next.activate_latency = wr_data;
                drbrt_pkg::REG_PRECHARGE: cfg_next.precharge_latency = wr_data;
                drbrt_pkg::REG_POLICY:    cfg_next.closed_policy = wr_data[0];
                drbrt_pkg::REG_LINE:
                    cfg_next.line_shift = wr_data[drbrt_pkg::SHIFT_W-1:0];
                drbrt_pkg::REG_ROW:
                    cfg_next.row_shift = wr_data[drbrt_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cas_latency       <= 8'd9;
            cfg_reg.activate_latency  <= 8'd9;
            cfg_reg.precharge_latency <= 8'd9;
            cfg_reg.closed_policy     <= 1'b1;
            cfg_reg.line_shift        <= 5'd6;
            cfg_reg.row_shift         <= 5'd13;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/drbrt_bank_table.sv @@
// per-bank busy, open and row storage with one lookup port and one update port
// depends on drbrt_pkg

module drbrt_bank_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [drbrt_pkg::IDX_W-1:0] lkp_bank,
    output drbrt_pkg::lkp_t             lkp,
    input  drbrt_pkg::upd_t             upd
);

    logic [drbrt_pkg::NUM_BANKS-1:0] busy_reg;
    logic [drbrt_pkg::NUM_BANKS-1:0] busy_next;
    logic [drbrt_pkg::NUM_BANKS-1:0] open_reg;
    logic [drbrt_pkg::NUM_BANKS-1:0] open_next;
    logic [drbrt_pkg::ROW_W-1:0]     row_reg [drbrt_pkg::NUM_BANKS];

    always_comb
    begin
        busy_next = busy_reg;
        open_next = open_reg;
        if (upd.en)
        begin
            if (upd.set_busy)
                busy_next[upd.bank] = 1'b1;
            if (upd.clr_busy)
                busy_next[upd.bank] = 1'b0;
            if (upd.set_open)
                open_next[upd.bank] = 1'b1;
            if (upd.clr_open)
                open_next[upd.bank] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            open_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            open_reg <= open_next;
        end
    end

    // row tags hold garbage until first written; only read while open
    always_ff @(posedge clk)
    begin
        if (upd.en && upd.set_open)
            row_reg[upd.bank] <= upd.row;
    end

    assign lkp.busy = busy_reg[lkp_bank];
    assign lkp.open = open_reg[lkp_bank];
    assign lkp.row  = row_reg[lkp_bank];

endmodule

@@ src/drbrt_decide.sv @@
// decode of one word: bank and row mapping, hit check, latency and state update
// depends on drbrt_pkg; combinational, fed from the input register

module drbrt_decide (
    input  logic                        valid,
    input  drbrt_pkg::item_t            item,
    input  drbrt_pkg::cfg_t             cfg,
    output logic [drbrt_pkg::IDX_W-1:0] lkp_bank,
    input  drbrt_pkg::lkp_t             lkp,
    output drbrt_pkg::result_t          result,
    output drbrt_pkg::upd_t             upd
);

    logic [drbrt_pkg::ADDR_W-1:0]  line_addr;
    logic [drbrt_pkg::ADDR_W-1:0]  row_addr;
    logic [drbrt_pkg::IDX_W-1:0]   issue_bank;
    logic [drbrt_pkg::IDX_W-1:0]   ev_bank;
    logic [drbrt_pkg::ROW_W-1:0]   row;
    logic                          issue_in_range;
    logic                          ev_in_range;
    logic                          hit;
    logic [drbrt_pkg::DELAY_W-1:0] cas_ext;
    logic [drbrt_pkg::DELAY_W-1:0] act_ext;
    logic [drbrt_pkg::DELAY_W-1:0] pre_ext;

    assign line_addr  = item.address >> cfg.line_shift;
    assign row_addr   = item.address >> cfg.row_shift;
    assign issue_bank = line_addr[drbrt_pkg::IDX_W-1:0] & drbrt_pkg::BANK_MASK;
    assign ev_bank    = drbrt_pkg::IDX_W'(item.event_bank);
    assign row        = row_addr[drbrt_pkg::ROW_W-1:0];

    assign issue_in_range = 32'(issue_bank) < drbrt_pkg::NUM_BANKS;
    assign ev_in_range    = 32'(item.event_bank) < drbrt_pkg::NUM_BANKS;

    assign lkp_bank = (item.kind == drbrt_pkg::KIND_ISSUE) ? issue_bank : ev_bank;
    assign hit      = lkp.open && (lkp.row == row);

    assign cas_ext = drbrt_pkg::DELAY_W'(cfg.cas_latency);
    assign act_ext = drbrt_pkg::DELAY_W'(cfg.activate_latency);
    assign pre_ext = drbrt_pkg::DELAY_W'(cfg.precharge_latency);

    always_comb
    begin
        result       = '0;
        upd          = '0;
        upd.bank     = lkp_bank;
        upd.row      = row;
        unique case (item.kind)
            drbrt_pkg::KIND_ISSUE:
            begin
                result.out_bank    = drbrt_pkg::EBANK_W'(issue_bank);
                result.resp_req_id = item.req_id;
                if (issue_in_range && !lkp.busy)
                begin
                    result.accepted       = 1'b1;
                    result.schedule_valid = 1'b1;
                    result.schedule_kind  = drbrt_pkg::KIND_ACCESS;
                    upd.en                = valid;
                    upd.set_busy          = 1'b1;
                    if (hit)
                    begin
                        result.row_outcome    = drbrt_pkg::OUT_HIT;
                        result.schedule_delay = cas_ext;
                    end
                    else if (lkp.open)
                    begin
                        result.row_outcome    = drbrt_pkg::OUT_WRONG;
                        result.schedule_delay = cas_ext + act_ext + pre_ext;
                        upd.set_open          = 1'b1;
                    end
                    else
                    begin
                        result.row_outcome    = drbrt_pkg::OUT_EMPTY;
                        result.schedule_delay = cas_ext + act_ext;
                        upd.set_open          = 1'b1;
                    end
                end
            end
            drbrt_pkg::KIND_ACCESS:
            begin
                result.out_bank = item.event_bank;
                if (ev_in_range)
                begin
                    result.respond     = 1'b1;
                    result.resp_req_id = item.req_id;
                    if (cfg.closed_policy)
                    begin
                        result.schedule_valid = 1'b1;
                        result.schedule_kind  = drbrt_pkg::KIND_PRECHARGE;
                        result.schedule_delay = pre_ext;
                    end
                    else
                    begin
                        upd.en       = valid;
                        upd.clr_busy = 1'b1;
                    end
                end
            end
            drbrt_pkg::KIND_PRECHARGE:
            begin
                result.out_bank = item.event_bank;
                if (ev_in_range)
                begin
                    upd.en       = valid;
                    upd.clr_busy = 1'b1;
                    upd.clr_open = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ src/dram_bank_row_timing_top.sv @@
// top level of the dram bank row timing block
// depends on drbrt_pkg, drbrt_cfg_regs, drbrt_bank_table, drbrt_decide
//
// tracks the open row and busy state of each dram bank. each input word is
// an issue request, an access-finished event or a precharge-finished event.
// input channel: a word is taken at a clock edge with start high and busy low.
// busy never rises, so a word may be given on every cycle.
// output channel: done is high for exactly one cycle with the result word on
// result; the receiver cannot stall, so every result must be taken as shown.
// pipeline: a taken word is held in the input register, then goes through the
// bank lookup and latency add into the result register. throughput is one
// word per cycle; the bank table is read and updated in the same cycle, so
// back to back words on the same bank see each other's updates.
// configuration: cfg_valid/cfg_ready write channel, always ready, carrying a
// register index and data; write only while no word is in flight.
// reset: all banks idle with no row open, registers at defaults, no result.

module dram_bank_row_timing_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  drbrt_pkg::item_t                item,
    output logic                            done,
    output drbrt_pkg::result_t              result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [drbrt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drbrt_pkg::CFG_DAT_W-1:0] cfg_data
);

    drbrt_pkg::cfg_t             cfg;
    drbrt_pkg::lkp_t             lkp;
    drbrt_pkg::upd_t             upd;
    drbrt_pkg::result_t          result_next;
    logic [drbrt_pkg::IDX_W-1:0] lkp_bank;

    logic               in_valid_reg;
    drbrt_pkg::item_t   item_reg;
    logic               done_reg;
    drbrt_pkg::result_t result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    drbrt_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    drbrt_bank_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .lkp_bank (lkp_bank),
        .lkp      (lkp),
        .upd      (upd)
    );

    drbrt_decide u_decide (
        .valid    (in_valid_reg),
        .item     (item_reg),
        .cfg      (cfg),
        .lkp_bank (lkp_bank),
        .lkp      (lkp),
        .result   (result_next),
        .upd      (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
        if (in_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("word taken without a result two cycles later");

    a_issue_sched: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.accepted |->
            result.schedule_valid && result.schedule_kind == drbrt_pkg::KIND_ACCESS
            && !result.respond)
        else $error("accepted issue without an access-finished schedule");

    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.accepted |-> result.row_outcome == drbrt_pkg::OUT_HIT)
        else $error("row outcome reported for a word that was not taken");

    a_same_bank: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(done) && result.accepted && $past(result.accepted)
            |-> result.out_bank != $past(result.out_bank))
        else $error("two back to back issues accepted on the same bank");

endmodule
